>>> design/ubcc_pkg.sv
// Shared types and constants for the UTF-8 boundary code point classifier.
package ubcc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W = 21;
   localparam int unsigned CLS_W = 3;
   localparam int unsigned CNT_W = 3;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 24;

   localparam logic [CLS_W-1:0] CLS_INVALID = 3'd0;
   localparam logic [CLS_W-1:0] CLS_ASCII_SPACE = 3'd1;
   localparam logic [CLS_W-1:0] CLS_ASCII_OTHER = 3'd2;
   localparam logic [CLS_W-1:0] CLS_UNI_SPACE = 3'd3;
   localparam logic [CLS_W-1:0] CLS_UNI_OTHER = 3'd4;

   localparam logic [1:0] LEN_ONE = 2'd0;
   localparam logic [1:0] LEN_TWO = 2'd1;
   localparam logic [1:0] LEN_THREE = 2'd2;
   localparam logic [1:0] LEN_FOUR = 2'd3;

   localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
   localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_prev_1;
      logic [BYTE_W-1:0] byte_prev_2;
      logic [BYTE_W-1:0] byte_prev_3;
      logic [BYTE_W-1:0] byte_prev_4;
      logic [CNT_W-1:0] bytes_available;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] lead;
      logic [BYTE_W-1:0] byte_prev_1;
      logic [5:0] tail_2;
      logic [5:0] tail_3;
      logic [1:0] len_code;
      logic text_start;
      logic strict_mode;
   } scan_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic point_valid;
      logic strict_mode;
   } dec_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic [CLS_W-1:0] point_class;
      logic point_valid;
      logic prior_is_space;
   } rsp_type;

   function automatic logic ascii_ws(input logic [CP_W-1:0] c);
      ascii_ws = (c == 21'h20) || (c >= 21'h09 && c <= 21'h0D);
   endfunction

   function automatic logic uni_ws(input logic [CP_W-1:0] c);
      uni_ws = (c == 21'h0085) || (c == 21'h00A0) || (c == 21'h1680) ||
               (c == 21'h2028) || (c == 21'h2029) || (c == 21'h202F) ||
               (c == 21'h205F) || (c == 21'h2060) || (c == 21'h3000) ||
               (c >= 21'h2000 && c <= 21'h200A);
   endfunction

   function automatic logic is_cont(input logic [BYTE_W-1:0] b);
      is_cont = (b[7:6] == 2'b10);
   endfunction

endpackage

>>> design/utf8_boundary_codepoint_classifier.sv
// Top level of the UTF-8 boundary code point classifier.
//
// Channel   Direction   Contents
// req_      in          bytes before a chunk boundary and their count
// rsp_      out         last code point, its class and space flag
// csr_      in          strict_mode register write
//
// A transaction passes one register per stage (scan, decode, classify) from req_
// to rsp_, and a new one may enter in every cycle unless rsp_ stalls a full pipeline.
// Reset clears the stage valid bits and sets strict_mode to 0.
// Each stage holds its transaction while the stage after it is full and stalled.
module utf8_boundary_codepoint_classifier
   import ubcc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // byte_prev_1, byte_prev_2, byte_prev_3, byte_prev_4, bytes_available, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // code_point, point_valid, prior_is_space, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // point_class
   output logic [CLS_W-1:0] rsp_tuser,
   input  logic csr_wr_en,
   input  logic [0:0] csr_wr_data
);

   logic strict_mode_ff;
   req_type req_data;
   scan_type scan_data;
   dec_type dec_data;
   rsp_type rsp_data;
   logic scan_valid, scan_ready;
   logic dec_valid, dec_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         strict_mode_ff <= csr_wr_data[0];
      end
   end

   assign req_data.byte_prev_1 = req_tdata[7:0];
   assign req_data.byte_prev_2 = req_tdata[15:8];
   assign req_data.byte_prev_3 = req_tdata[23:16];
   assign req_data.byte_prev_4 = req_tdata[31:24];
   assign req_data.bytes_available = req_tdata[34:32];

   ubcc_scan u_scan (
      .clock(clock),
      .reset(reset),
      .strict_mode(strict_mode_ff),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_data(req_data),
      .out_valid(scan_valid),
      .out_ready(scan_ready),
      .out_data(scan_data)
   );

   ubcc_decode u_decode (
      .clock(clock),
      .reset(reset),
      .in_valid(scan_valid),
      .in_ready(scan_ready),
      .in_data(scan_data),
      .out_valid(dec_valid),
      .out_ready(dec_ready),
      .out_data(dec_data)
   );

   ubcc_classify u_classify (
      .clock(clock),
      .reset(reset),
      .in_valid(dec_valid),
      .in_ready(dec_ready),
      .in_data(dec_data),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data(rsp_data)
   );

   assign rsp_tdata = {1'b0, rsp_data.prior_is_space, rsp_data.point_valid,
                       rsp_data.code_point};
   assign rsp_tuser = rsp_data.point_class;

endmodule

>>> design/ubcc_scan.sv
// First stage: saturates the count, backs up over continuation bytes and picks the lead byte.
module ubcc_scan
   import ubcc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic strict_mode,
   input  logic in_valid,
   output logic in_ready,
   input  req_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output scan_type out_data
);

   logic valid_ff, valid_in;
   scan_type data_ff, data_in;
   logic [CNT_W-1:0] count;
   logic [1:0] len_code;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      count = (in_data.bytes_available > 3'd4) ? 3'd4 : in_data.bytes_available;
      len_code = LEN_ONE;
      if (count > 3'd1 && is_cont(in_data.byte_prev_1)) begin
         len_code = LEN_TWO;
         if (count > 3'd2 && is_cont(in_data.byte_prev_2)) begin
            len_code = LEN_THREE;
            if (count > 3'd3 && is_cont(in_data.byte_prev_3)) begin
               len_code = LEN_FOUR;
            end
         end
      end
      data_in.byte_prev_1 = in_data.byte_prev_1;
      data_in.tail_2 = in_data.byte_prev_2[5:0];
      data_in.tail_3 = in_data.byte_prev_3[5:0];
      data_in.len_code = len_code;
      data_in.text_start = (count == 3'd0);
      data_in.strict_mode = strict_mode;
      case (len_code)
         LEN_ONE: data_in.lead = in_data.byte_prev_1;
         LEN_TWO: data_in.lead = in_data.byte_prev_2;
         LEN_THREE: data_in.lead = in_data.byte_prev_3;
         default: data_in.lead = in_data.byte_prev_4;
      endcase
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

>>> design/ubcc_decode.sv
// Second stage: in strict mode, decodes UTF-8 and rejects bad forms.
module ubcc_decode
   import ubcc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  scan_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output dec_type out_data
);

   logic valid_ff, valid_in;
   dec_type data_ff, data_in;
   logic [BYTE_W-1:0] lead;
   logic [5:0] t1;
   logic [CP_W-1:0] val;
   logic [CP_W-1:0] minv;
   logic lead_ok;
   logic [1:0] need;
   logic ok;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      lead = in_data.lead;
      t1 = in_data.byte_prev_1[5:0];
      lead_ok = 1'b1;
      need = LEN_ONE;
      val = {13'd0, lead};
      minv = 21'd0;
      if (lead < 8'h80) begin
         need = LEN_ONE;
      end else if (lead >= 8'hC2 && lead <= 8'hDF) begin
         need = LEN_TWO;
         val = {10'd0, lead[4:0], t1};
         minv = 21'h80;
      end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
         need = LEN_THREE;
         val = {5'd0, lead[3:0], in_data.tail_2, t1};
         minv = 21'h800;
      end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
         need = LEN_FOUR;
         val = {lead[2:0], in_data.tail_3, in_data.tail_2, t1};
         minv = 21'h10000;
      end else begin
         lead_ok = 1'b0;
      end
      ok = lead_ok && (need == in_data.len_code) && (val >= minv) && (val <= CP_MAX) &&
           !(val >= 21'hD800 && val <= 21'hDFFF);
      data_in.strict_mode = in_data.strict_mode;
      if (in_data.text_start) begin
         data_in.code_point = CP_SPACE;
         data_in.point_valid = 1'b1;
      end else if (!in_data.strict_mode) begin
         data_in.code_point = {13'd0, in_data.byte_prev_1};
         data_in.point_valid = 1'b1;
      end else begin
         data_in.code_point = ok ? val : 21'd0;
         data_in.point_valid = ok;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

>>> design/ubcc_classify.sv
// Third stage: assigns the class and the whitespace flag to the decoded code point.
module ubcc_classify
   import ubcc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  dec_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output rsp_type out_data
);

   logic valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic [CLS_W-1:0] cls;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (!in_data.point_valid) begin
         cls = CLS_INVALID;
      end else if (in_data.code_point <= 21'h7F) begin
         cls = ascii_ws(in_data.code_point) ? CLS_ASCII_SPACE : CLS_ASCII_OTHER;
      end else if (in_data.strict_mode && uni_ws(in_data.code_point)) begin
         cls = CLS_UNI_SPACE;
      end else begin
         cls = CLS_UNI_OTHER;
      end
      data_in.code_point = in_data.code_point;
      data_in.point_class = cls;
      data_in.point_valid = in_data.point_valid;
      data_in.prior_is_space = (cls == CLS_ASCII_SPACE) || (cls == CLS_UNI_SPACE);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

>>> dv/tb_utf8_boundary_codepoint_classifier.sv
// Self-checking testbench for the UTF-8 boundary code point classifier.
module tb_utf8_boundary_codepoint_classifier;
   import ubcc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned ERR_SHOWN = 10;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // byte_prev_1, byte_prev_2, byte_prev_3, byte_prev_4, bytes_available, zero fill
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // code_point, point_valid, prior_is_space, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // point_class
   logic [CLS_W-1:0] rsp_tuser;
   logic csr_wr_en;
   logic [0:0] csr_wr_data;

   rsp_type pending_points[$];
   logic strict_shadow;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_left;
   int unsigned mismatch_count;
   int unsigned stall_cycles;

   int unsigned notable_points [28] = '{
      'h09, 'h0D, 'h20, 'h08, 'h0E, 'h7F, 'h80, 'h85, 'hA0, 'h7FF, 'h800, 'h1680,
      'h1FFF, 'h2000, 'h200A, 'h200B, 'h2028, 'h2029, 'h202F, 'h205F, 'h2060,
      'h2061, 'h3000, 'hD7FF, 'hE000, 'hFFFF, 'h10000, 'h10FFFF};

   utf8_boundary_codepoint_classifier u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic space_char(input int unsigned c, input logic wide);
      logic ws;
      ws = (c == 'h20) || (c >= 'h09 && c <= 'h0D);
      if (wide) begin
         ws = ws || c == 'h85 || c == 'hA0 || c == 'h1680 || c == 'h2028 ||
              c == 'h2029 || c == 'h202F || c == 'h205F || c == 'h2060 ||
              c == 'h3000 || (c >= 'h2000 && c <= 'h200A);
      end
      return ws;
   endfunction

   function automatic rsp_type predict_codepoint(input logic [31:0] window,
                                                 input logic [2:0] avail,
                                                 input logic strict);
      rsp_type r;
      logic [7:0] win [1:4];
      logic [7:0] lead;
      int unsigned n, len, need, k, val, minv;
      logic ok;
      r = '0;
      for (k = 1; k <= 4; k++) win[k] = window[8*(k-1) +: 8];
      n = (avail > 3'd4) ? 4 : {29'd0, avail};
      if (n == 0) begin
         r.code_point = CP_SPACE;
         r.point_class = CLS_ASCII_SPACE;
         r.point_valid = 1'b1;
         r.prior_is_space = 1'b1;
      end else if (!strict) begin
         r.code_point = {13'd0, win[1]};
         r.point_valid = 1'b1;
         if (win[1] <= 8'h7F) begin
            r.point_class = space_char({24'd0, win[1]}, 1'b0) ?
                            CLS_ASCII_SPACE : CLS_ASCII_OTHER;
         end else begin
            r.point_class = CLS_UNI_OTHER;
         end
         r.prior_is_space = (r.point_class == CLS_ASCII_SPACE);
      end else begin
         len = 1;
         while (len < n && win[len][7:6] == 2'b10) len++;
         lead = win[len];
         ok = 1'b1;
         need = 1;
         val = 0;
         minv = 0;
         if (lead < 8'h80) begin
            val = {24'd0, lead};
         end else if (lead >= 8'hC2 && lead <= 8'hDF) begin
            need = 2; val = {27'd0, lead[4:0]}; minv = 'h80;
         end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
            need = 3; val = {28'd0, lead[3:0]}; minv = 'h800;
         end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
            need = 4; val = {29'd0, lead[2:0]}; minv = 'h10000;
         end else begin
            ok = 1'b0;
         end
         if (len != need) ok = 1'b0;
         if (ok) begin
            for (k = len - 1; k >= 1; k--) begin
               if (win[k][7:6] != 2'b10) ok = 1'b0;
               val = (val << 6) | {26'd0, win[k][5:0]};
            end
         end
         if (ok && (val < minv || val > CP_MAX || (val >= 'hD800 && val <= 'hDFFF))) begin
            ok = 1'b0;
         end
         if (ok) begin
            r.code_point = val[CP_W-1:0];
            r.point_valid = 1'b1;
            if (val <= 'h7F) begin
               r.point_class = space_char(val, 1'b0) ? CLS_ASCII_SPACE : CLS_ASCII_OTHER;
            end else begin
               r.point_class = space_char(val, 1'b1) ? CLS_UNI_SPACE : CLS_UNI_OTHER;
            end
            r.prior_is_space = (r.point_class == CLS_ASCII_SPACE) ||
                               (r.point_class == CLS_UNI_SPACE);
         end
      end
      return r;
   endfunction

   function automatic int unsigned utf8_length(input int unsigned cp);
      if (cp < 'h80) return 1;
      if (cp < 'h800) return 2;
      if (cp < 'h10000) return 3;
      return 4;
   endfunction

   // The lead byte lands in byte_prev_<seq_len>; bytes beyond it stay random.
   function automatic logic [31:0] encode_utf8(input int unsigned cp,
                                               input int unsigned seq_len);
      logic [31:0] window;
      logic [7:0] prefix, mask;
      int unsigned k;
      window = $urandom;
      for (k = 0; k + 1 < seq_len; k++) begin
         window[8*k +: 8] = 8'h80 | 8'((cp >> (6*k)) & 'h3F);
      end
      case (seq_len)
         1: begin prefix = 8'h00; mask = 8'h7F; end
         2: begin prefix = 8'hC0; mask = 8'h1F; end
         3: begin prefix = 8'hE0; mask = 8'h0F; end
         default: begin prefix = 8'hF0; mask = 8'h07; end
      endcase
      window[8*(seq_len-1) +: 8] = prefix | (8'(cp >> (6*(seq_len-1))) & mask);
      return window;
   endfunction

   task automatic draw_boundary(output logic [31:0] window, output logic [2:0] avail);
      int unsigned pick, cp, seq_len, pos;
      pick = $urandom_range(99);
      if (pick < 75) begin
         if (pick < 15) begin
            cp = notable_points[$urandom_range(27)];
         end else begin
            case ($urandom_range(3))
               0: cp = $urandom_range('h7F, 0);
               1: cp = $urandom_range('h7FF, 'h80);
               2: cp = $urandom_range('hFFFF, 'h800);
               default: cp = $urandom_range('h10FFFF, 'h10000);
            endcase
         end
         seq_len = utf8_length(cp);
         window = encode_utf8(cp, seq_len);
         avail = 3'($urandom_range(7, seq_len));
         if (pick >= 60) begin
            case ($urandom_range(3))
               0: begin
                  if (seq_len < 4) begin
                     seq_len = seq_len + 1 + $urandom_range(3 - seq_len);
                     cp = cp & ((1 << (6 * seq_len - 6)) - 1);
                  end else begin
                     cp = $urandom_range('h1FFFFF, 'h110000);
                  end
                  window = encode_utf8(cp, seq_len);
                  avail = 3'($urandom_range(7, seq_len));
               end
               1: begin
                  window = encode_utf8($urandom_range('hDFFF, 'hD800), 3);
                  avail = 3'($urandom_range(7, 3));
               end
               2: begin
                  pos = $urandom_range(3);
                  window[8*pos +: 8] = 8'($urandom);
               end
               default: avail = 3'($urandom_range(seq_len, 1));
            endcase
         end
      end else if (pick < 92) begin
         window = $urandom;
         avail = 3'($urandom_range(7));
      end else begin
         window = $urandom;
         avail = 3'd0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer_boundary(input logic [31:0] window, input logic [2:0] avail);
      rsp_type expected;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, avail, window};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected = predict_codepoint(window, avail, strict_shadow);
      pending_points = {pending_points, expected};
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_strict_mode(input logic mode);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      strict_shadow = mode;
   endtask

   task automatic test_fast_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      offer_boundary(32'hFFFF_FFFF, 3'd0);
      offer_boundary(32'h0000_0020, 3'd1);
      offer_boundary(32'h1234_5609, 3'd2);
      offer_boundary(32'h0000_000D, 3'd4);
      offer_boundary(32'h0000_0008, 3'd1);
      offer_boundary(32'hC2E2_F00E, 3'd3);
      offer_boundary(32'hFFFF_FF00, 3'd1);
      offer_boundary(32'h0000_007F, 3'd1);
      offer_boundary(32'h0000_C280, 3'd2);
      offer_boundary(32'hFFFF_FFFF, 3'd7);
      offer_boundary(32'h8080_8041, 3'd5);
      drain_results();
   endtask

   task automatic test_strict_directed();
      write_strict_mode(1'b1);
      offer_boundary(32'h0000_0000, 3'd0);
      offer_boundary(32'hFFFF_FF0A, 3'd1);
      offer_boundary(32'h0000_C2A0, 3'd2);
      offer_boundary(32'h00E3_8080, 3'd3);
      offer_boundary(32'hF48F_BFBF, 3'd4);
      offer_boundary(32'h0000_C080, 3'd2);
      offer_boundary(32'h00ED_A080, 3'd3);
      offer_boundary(32'hF490_8080, 3'd4);
      offer_boundary(32'h8080_8080, 3'd4);
      offer_boundary(32'h0000_4180, 3'd2);
      offer_boundary(32'h0000_0080, 3'd1);
      offer_boundary(32'h00E2_80A8, 3'd2);
      offer_boundary(32'h0000_00FF, 3'd1);
      offer_boundary(32'h4100_C285, 3'd6);
      drain_results();
   endtask

   task automatic test_random(input int unsigned count, input int unsigned sidle,
                              input int unsigned ridle);
      int unsigned sent, block;
      logic [31:0] window;
      logic [2:0] avail;
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      sent = 0;
      while (sent < count) begin
         block = $urandom_range(90, 40);
         repeat (block) begin
            draw_boundary(window, avail);
            offer_boundary(window, avail);
         end
         sent += block;
         drain_results();
         write_strict_mode(1'($urandom_range(1)));
      end
   endtask

   // The receiver holds off while items keep coming, so the pipeline fills
   // and the input stalls.
   task automatic test_back_pressure();
      logic [31:0] window;
      logic [2:0] avail;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = 60;
      repeat (40) begin
         draw_boundary(window, avail);
         offer_boundary(window, avail);
      end
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      strict_shadow = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_left = 0;
      mismatch_count = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_fast_directed();
      test_strict_directed();
      write_strict_mode(1'b0);
      test_random(550, 24, 46);
      test_random(550, 46, 24);
      test_back_pressure();
      test_random(450, 0, 0);
      drain_results();
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ERR_SHOWN) begin
               $display("Unexpected transaction: tdata %h tuser %0d", rsp_tdata, rsp_tuser);
            end
         end else begin
            want = pending_points.pop_front();
            if (rsp_tdata[CP_W-1:0] !== want.code_point ||
                rsp_tuser !== want.point_class ||
                rsp_tdata[CP_W] !== want.point_valid ||
                rsp_tdata[CP_W+1] !== want.prior_is_space) begin
               mismatch_count++;
               if (mismatch_count <= ERR_SHOWN) begin
                  $display("Mismatch: expected cp %h class %0d valid %b space %b",
                           want.code_point, want.point_class, want.point_valid,
                           want.prior_is_space);
                  $display("          actual   cp %h class %0d valid %b space %b",
                           rsp_tdata[CP_W-1:0], rsp_tuser, rsp_tdata[CP_W],
                           rsp_tdata[CP_W+1]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
